FILE: src/elra_pkg.sv
// ----------------------------------------------------------------------------
// elra_pkg
// Shared constants, register codes and types of the LED ring animator.
// ----------------------------------------------------------------------------
package elra_pkg;

   localparam int LED_COUNT  = 16;
   localparam int RING_W     = $clog2(LED_COUNT);
   localparam int MASK_W     = 16;
   localparam int PERIOD_W   = 10;
   localparam int QUIET_W    = 8;
   localparam int TAIL_W     = 5;
   localparam int STEP_W     = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   // Signed width that holds period +/- step without overflow.
   localparam int SUM_W = PERIOD_W + 2;

   localparam logic [PERIOD_W-1:0] RUNNER_PERIOD_RST = PERIOD_W'(80);
   localparam logic [PERIOD_W-1:0] TAIL_PERIOD_RST   = PERIOD_W'(60);
   localparam logic [PERIOD_W-1:0] ELAPSED_MAX       = {PERIOD_W{1'b1}};
   localparam logic [QUIET_W-1:0]  QUIET_MAX         = {QUIET_W{1'b1}};

   localparam logic [TAIL_W-1:0]   TAIL_LENGTH_RST   = TAIL_W'(4);
   localparam logic [QUIET_W-1:0]  DEBOUNCE_RST      = QUIET_W'(10);
   localparam logic [STEP_W-1:0]   PERIOD_STEP_RST   = STEP_W'(5);
   localparam logic [PERIOD_W-1:0] PERIOD_MIN_RST    = PERIOD_W'(10);
   localparam logic [PERIOD_W-1:0] PERIOD_MAX_RST    = PERIOD_W'(400);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIRECTION   = 3'd0,
      CSR_TAIL_LENGTH = 3'd1,
      CSR_DEBOUNCE_MS = 3'd2,
      CSR_PERIOD_STEP = 3'd3,
      CSR_PERIOD_MIN  = 3'd4,
      CSR_PERIOD_MAX  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                direction;
      logic [TAIL_W-1:0]   tail_length;
      logic [QUIET_W-1:0]  debounce_ms;
      logic [STEP_W-1:0]   period_step;
      logic [PERIOD_W-1:0] period_min;
      logic [PERIOD_W-1:0] period_max;
   } cfg_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] runner_period;
      logic [PERIOD_W-1:0] tail_period;
      logic                changed;
   } speed_type;

   typedef struct packed {
      logic [MASK_W-1:0] led_mask;
      logic              written;
   } anim_type;

endpackage

FILE: src/elra_req_if.sv
// ----------------------------------------------------------------------------
// elra_req_if
// Input channel: one word per millisecond tick with encoder and button samples.
// ----------------------------------------------------------------------------
interface elra_req_if;
   logic valid;
   logic ready;
   logic enc_a;
   logic enc_b;
   logic button_n;

   modport source (output valid, output enc_a, output enc_b, output button_n,
                   input ready);
   modport sink   (input valid, input enc_a, input enc_b, input button_n,
                   output ready);
endinterface

FILE: src/elra_rsp_if.sv
// ----------------------------------------------------------------------------
// elra_rsp_if
// Result channel: LED mask, mode and periods after each tick.
// ----------------------------------------------------------------------------
interface elra_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [elra_pkg::MASK_W-1:0]   led_mask;
   logic                          mask_written;
   logic                          tail_mode;
   logic [elra_pkg::PERIOD_W-1:0] runner_period;
   logic [elra_pkg::PERIOD_W-1:0] tail_period;
   logic                          speed_changed;

   modport source (output valid, output led_mask, output mask_written,
                   output tail_mode, output runner_period, output tail_period,
                   output speed_changed, input ready);
   modport sink   (input valid, input led_mask, input mask_written,
                   input tail_mode, input runner_period, input tail_period,
                   input speed_changed, output ready);
endinterface

FILE: src/elra_speed.sv
// ----------------------------------------------------------------------------
// elra_speed
// Encoder step detection and clamped update of both animation periods.
// ----------------------------------------------------------------------------
module elra_speed (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                enc_a,
   input  logic                enc_b,
   input  elra_pkg::cfg_type   cfg,
   output elra_pkg::speed_type speed
);

   logic                          prev_a_ff, prev_a_in;
   logic [elra_pkg::PERIOD_W-1:0] runner_ff, runner_in;
   logic [elra_pkg::PERIOD_W-1:0] tail_ff, tail_in;

   function automatic logic [elra_pkg::PERIOD_W-1:0] clamp_period(
      input logic signed [elra_pkg::SUM_W-1:0] v,
      input logic [elra_pkg::PERIOD_W-1:0]     pmin,
      input logic [elra_pkg::PERIOD_W-1:0]     pmax
   );
      logic signed [elra_pkg::SUM_W-1:0] smin;
      logic signed [elra_pkg::SUM_W-1:0] smax;
      logic [elra_pkg::PERIOD_W-1:0]     r;
      smin = $signed({2'b00, pmin});
      smax = $signed({2'b00, pmax});
      if (v < smin) begin
         r = pmin;
      end else if (v > smax) begin
         r = pmax;
      end else begin
         r = v[elra_pkg::PERIOD_W-1:0];
      end
      return r;
   endfunction

   logic                              step;
   logic signed [elra_pkg::SUM_W-1:0] change;

   always_comb begin
      step   = (enc_a != prev_a_ff);
      // clockwise (A == B) shortens the periods
      change = (enc_a == enc_b) ?  $signed({6'b0, cfg.period_step})
                                : -$signed({6'b0, cfg.period_step});
      prev_a_in = prev_a_ff;
      runner_in = runner_ff;
      tail_in   = tail_ff;
      if (step) begin
         prev_a_in = enc_a;
         runner_in = clamp_period($signed({2'b00, runner_ff}) - change,
                                  cfg.period_min, cfg.period_max);
         tail_in   = clamp_period($signed({2'b00, tail_ff}) - change,
                                  cfg.period_min, cfg.period_max);
      end
      speed.runner_period = runner_in;
      speed.tail_period   = tail_in;
      speed.changed       = step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff <= 1'b1;
         runner_ff <= elra_pkg::RUNNER_PERIOD_RST;
         tail_ff   <= elra_pkg::TAIL_PERIOD_RST;
      end else if (advance) begin
         prev_a_ff <= prev_a_in;
         runner_ff <= runner_in;
         tail_ff   <= tail_in;
      end
   end

endmodule

FILE: src/elra_button.sv
// ----------------------------------------------------------------------------
// elra_button
// Button debounce and mode toggle on each accepted press.
// ----------------------------------------------------------------------------
module elra_button (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              button_n,
   input  elra_pkg::cfg_type cfg,
   output logic              mode_next
);

   logic                         pressed_ff, pressed_in;
   logic [elra_pkg::QUIET_W-1:0] quiet_ff, quiet_in;
   logic                         mode_ff, mode_in;

   logic                         pressed_now;
   logic [elra_pkg::QUIET_W-1:0] q;

   always_comb begin
      pressed_now = ~button_n;
      q = (quiet_ff != elra_pkg::QUIET_MAX) ? quiet_ff + 1'b1 : elra_pkg::QUIET_MAX;
      pressed_in = pressed_ff;
      mode_in    = mode_ff;
      quiet_in   = q;
      if ((pressed_now != pressed_ff) && (q > cfg.debounce_ms)) begin
         pressed_in = pressed_now;
         quiet_in   = '0;
         if (pressed_now) begin
            mode_in = ~mode_ff;
         end
      end
      mode_next = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff <= 1'b0;
         quiet_ff   <= elra_pkg::QUIET_MAX;
         mode_ff    <= 1'b0;
      end else if (advance) begin
         pressed_ff <= pressed_in;
         quiet_ff   <= quiet_in;
         mode_ff    <= mode_in;
      end
   end

endmodule

FILE: src/elra_anim.sv
// ----------------------------------------------------------------------------
// elra_anim
// Elapsed counters, ring positions and LED mask generation.
// ----------------------------------------------------------------------------
module elra_anim (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                mode,
   input  elra_pkg::speed_type speed,
   input  elra_pkg::cfg_type   cfg,
   output elra_pkg::anim_type  anim
);

   logic [elra_pkg::PERIOD_W-1:0] run_el_ff, run_el_in;
   logic [elra_pkg::PERIOD_W-1:0] tail_el_ff, tail_el_in;
   logic [elra_pkg::RING_W-1:0]   run_idx_ff, run_idx_in;
   logic [elra_pkg::RING_W-1:0]   head_ff, head_in;
   logic [elra_pkg::MASK_W-1:0]   mask_ff, mask_in;

   function automatic logic [elra_pkg::RING_W-1:0] ring_advance(
      input logic [elra_pkg::RING_W-1:0] pos,
      input logic                        dir
   );
      logic [elra_pkg::RING_W-1:0] r;
      if (dir) begin
         r = (pos == '0) ? elra_pkg::RING_W'(elra_pkg::LED_COUNT - 1) : pos - 1'b1;
      end else begin
         r = (pos == elra_pkg::RING_W'(elra_pkg::LED_COUNT - 1)) ? '0 : pos + 1'b1;
      end
      return r;
   endfunction

   function automatic logic [elra_pkg::MASK_W-1:0] bit_of(
      input logic [elra_pkg::RING_W-1:0] pos
   );
      logic [elra_pkg::MASK_W-1:0] r;
      r = '0;
      if (int'(pos) < elra_pkg::MASK_W) begin
         r = elra_pkg::MASK_W'(1) << pos;
      end
      return r;
   endfunction

   // LED p is lit when its ring distance behind the head is below tail_length.
   function automatic logic [elra_pkg::MASK_W-1:0] tail_mask(
      input logic [elra_pkg::RING_W-1:0] head,
      input logic                        dir,
      input logic [elra_pkg::TAIL_W-1:0] len
   );
      logic [elra_pkg::MASK_W-1:0] r;
      logic [elra_pkg::RING_W:0]   d;
      logic [elra_pkg::RING_W:0]   pe;
      logic [elra_pkg::RING_W:0]   he;
      r  = '0;
      he = {1'b0, head};
      for (int p = 0; p < elra_pkg::MASK_W; p++) begin
         pe = (elra_pkg::RING_W+1)'(p);
         d  = dir ? (pe - he) : (he - pe);
         if (d[elra_pkg::RING_W]) begin
            d = d + (elra_pkg::RING_W+1)'(elra_pkg::LED_COUNT);
         end
         if ((p < elra_pkg::LED_COUNT) && (int'(d) < int'(len))) begin
            r[p] = 1'b1;
         end
      end
      return r;
   endfunction

   logic [elra_pkg::PERIOD_W-1:0] run_inc;
   logic [elra_pkg::PERIOD_W-1:0] tail_inc;
   logic [elra_pkg::RING_W-1:0]   run_adv;
   logic [elra_pkg::RING_W-1:0]   head_adv;
   logic                          written;

   always_comb begin
      run_inc  = (run_el_ff  != elra_pkg::ELAPSED_MAX) ? run_el_ff  + 1'b1 : run_el_ff;
      tail_inc = (tail_el_ff != elra_pkg::ELAPSED_MAX) ? tail_el_ff + 1'b1 : tail_el_ff;
      run_adv  = ring_advance(run_idx_ff, cfg.direction);
      head_adv = ring_advance(head_ff, cfg.direction);
      run_el_in  = run_inc;
      tail_el_in = tail_inc;
      run_idx_in = run_idx_ff;
      head_in    = head_ff;
      mask_in    = mask_ff;
      written    = 1'b0;
      if (!mode) begin
         if (run_inc >= speed.runner_period) begin
            run_el_in  = '0;
            run_idx_in = run_adv;
            mask_in    = bit_of(run_adv);
            written    = 1'b1;
         end
      end else begin
         if (tail_inc >= speed.tail_period) begin
            tail_el_in = '0;
            head_in    = head_adv;
            mask_in    = tail_mask(head_adv, cfg.direction, cfg.tail_length);
            written    = 1'b1;
         end
      end
      anim.led_mask = mask_in;
      anim.written  = written;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_el_ff  <= '0;
         tail_el_ff <= '0;
         run_idx_ff <= '0;
         head_ff    <= '0;
         mask_ff    <= elra_pkg::MASK_W'(1);
      end else if (advance) begin
         run_el_ff  <= run_el_in;
         tail_el_ff <= tail_el_in;
         run_idx_ff <= run_idx_in;
         head_ff    <= head_in;
         mask_ff    <= mask_in;
      end
   end

endmodule

FILE: src/encoder_led_ring_animator_unit.sv
// ----------------------------------------------------------------------------
// encoder_led_ring_animator_unit
// Rotary encoder speed control and LED ring runner/tail animation.
// ----------------------------------------------------------------------------
// Usage:
//  - req_chan carries one word per millisecond tick: encoder A/B samples and
//    the active-low button level. rsp_chan returns exactly one word per tick:
//    LED mask, mask-written flag, mode, both periods and speed-changed flag.
//  - Six settings are written through csr_wr_en / csr_index / csr_wdata while
//    the unit is idle; they take effect on the next tick.
//  - Datapath: input register -> one pass of encoder, debounce and animation
//    logic -> result register. All tick state updates as a word moves from
//    the input register into the result register.
//  - Words go input register -> result register. Throughput: one word per
//    clock while rsp_chan keeps taking words, set by the single update pass.
//  - Stall: if rsp_chan is held off, the result register keeps its word and
//    the input register can still take one more word; req_chan.ready drops
//    only when both are full and the result is not being taken.
//  - Reset (synchronous, active high) empties both registers, restores the
//    default settings, periods 80/60 ms, runner mode and LED 0 lit.
// ----------------------------------------------------------------------------
module encoder_led_ring_animator_unit (
   input  logic                            clock,
   input  logic                            reset,
   elra_req_if.sink                        req_chan,
   elra_rsp_if.source                      rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [elra_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [elra_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // settings
   elra_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (elra_pkg::csr_index_type'(csr_index))
            elra_pkg::CSR_DIRECTION:   cfg_in.direction   = csr_wdata[0];
            elra_pkg::CSR_TAIL_LENGTH: cfg_in.tail_length = csr_wdata[elra_pkg::TAIL_W-1:0];
            elra_pkg::CSR_DEBOUNCE_MS: cfg_in.debounce_ms = csr_wdata[elra_pkg::QUIET_W-1:0];
            elra_pkg::CSR_PERIOD_STEP: cfg_in.period_step = csr_wdata[elra_pkg::STEP_W-1:0];
            elra_pkg::CSR_PERIOD_MIN:  cfg_in.period_min  = csr_wdata[elra_pkg::PERIOD_W-1:0];
            elra_pkg::CSR_PERIOD_MAX:  cfg_in.period_max  = csr_wdata[elra_pkg::PERIOD_W-1:0];
            default: ;  // unknown index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.direction   <= 1'b0;
         cfg_ff.tail_length <= elra_pkg::TAIL_LENGTH_RST;
         cfg_ff.debounce_ms <= elra_pkg::DEBOUNCE_RST;
         cfg_ff.period_step <= elra_pkg::PERIOD_STEP_RST;
         cfg_ff.period_min  <= elra_pkg::PERIOD_MIN_RST;
         cfg_ff.period_max  <= elra_pkg::PERIOD_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register
   logic in_valid_ff, in_valid_in;
   logic enc_a_ff, enc_b_ff, button_n_ff;
   logic out_valid_ff, out_valid_in;
   logic advance;   // word moves from input register to result register
   logic req_fire;

   assign advance        = in_valid_ff & (~out_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~in_valid_ff | advance;
   assign req_fire       = req_chan.valid & req_chan.ready;
   assign in_valid_in    = req_fire | (in_valid_ff & ~advance);
   assign out_valid_in   = advance | (out_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         enc_a_ff    <= req_chan.enc_a;
         enc_b_ff    <= req_chan.enc_b;
         button_n_ff <= req_chan.button_n;
      end
   end

   // tick update: encoder first, then button, then animation
   elra_pkg::speed_type speed;
   elra_pkg::anim_type  anim;
   logic                mode_next;

   elra_speed u_speed (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .enc_a   (enc_a_ff),
      .enc_b   (enc_b_ff),
      .cfg     (cfg_ff),
      .speed   (speed)
   );

   elra_button u_button (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .button_n  (button_n_ff),
      .cfg       (cfg_ff),
      .mode_next (mode_next)
   );

   elra_anim u_anim (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .mode    (mode_next),
      .speed   (speed),
      .cfg     (cfg_ff),
      .anim    (anim)
   );

   // result register
   logic [elra_pkg::MASK_W-1:0]   led_mask_ff;
   logic                          written_ff;
   logic                          mode_ff;
   logic [elra_pkg::PERIOD_W-1:0] runner_period_ff;
   logic [elra_pkg::PERIOD_W-1:0] tail_period_ff;
   logic                          changed_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         led_mask_ff      <= anim.led_mask;
         written_ff       <= anim.written;
         mode_ff          <= mode_next;
         runner_period_ff <= speed.runner_period;
         tail_period_ff   <= speed.tail_period;
         changed_ff       <= speed.changed;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.led_mask      = led_mask_ff;
   assign rsp_chan.mask_written  = written_ff;
   assign rsp_chan.tail_mode     = mode_ff;
   assign rsp_chan.runner_period = runner_period_ff;
   assign rsp_chan.tail_period   = tail_period_ff;
   assign rsp_chan.speed_changed = changed_ff;

endmodule

FILE: test/elra_tick_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// elra_tick_checker
// Watches the tick and status channels and the register port, keeps its own
// model of the encoder, debounce and ring animation, and compares every
// status word against the oldest predicted one.
// ----------------------------------------------------------------------------
module elra_tick_checker
   import elra_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   elra_req_if                   req_mon,
   elra_rsp_if                   rsp_mon,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fails,
   output int                    outstanding
);

   typedef struct packed {
      logic [MASK_W-1:0]   led_mask;
      logic                mask_written;
      logic                tail_mode;
      logic [PERIOD_W-1:0] runner_period;
      logic [PERIOD_W-1:0] tail_period;
      logic                speed_changed;
   } ring_status_type;

   ring_status_type status_due_q[$];
   int              fail_total = 0;
   int              due_count  = 0;

   // settings
   logic                cfg_dir;
   logic [TAIL_W-1:0]   cfg_tail_len;
   logic [QUIET_W-1:0]  cfg_debounce;
   logic [STEP_W-1:0]   cfg_step;
   logic [PERIOD_W-1:0] cfg_min;
   logic [PERIOD_W-1:0] cfg_max;

   // tick state
   logic                last_a;
   logic [PERIOD_W-1:0] run_per;
   logic [PERIOD_W-1:0] trail_per;
   logic [PERIOD_W-1:0] run_age;
   logic [PERIOD_W-1:0] trail_age;
   logic [RING_W-1:0]   run_pos;
   logic [RING_W-1:0]   trail_pos;
   logic                btn_down;
   logic [QUIET_W-1:0]  btn_quiet;
   logic                trail_on;
   logic [MASK_W-1:0]   lit;

   assign fails       = fail_total;
   assign outstanding = due_count;

   function automatic logic [PERIOD_W-1:0] clamp_to_limits(int value);
      int lo;
      int hi;
      lo = int'(cfg_min);
      hi = int'(cfg_max);
      if (value < lo) return cfg_min;
      if (value > hi) return cfg_max;
      return value[PERIOD_W-1:0];
   endfunction

   function automatic logic [RING_W-1:0] ring_next(logic [RING_W-1:0] pos);
      int p;
      p = int'(pos);
      if (cfg_dir) p = (p + LED_COUNT - 1) % LED_COUNT;
      else p = (p + 1) % LED_COUNT;
      return p[RING_W-1:0];
   endfunction

   function automatic logic [MASK_W-1:0] trail_mask(logic [RING_W-1:0] head);
      logic [MASK_W-1:0] m;
      int                h;
      int                off;
      int                pos;
      m = '0;
      h = int'(head);
      for (int i = 0; i < int'(cfg_tail_len); i++) begin
         off = i % LED_COUNT;
         if (cfg_dir) pos = (h + off) % LED_COUNT;
         else pos = (h + LED_COUNT - off) % LED_COUNT;
         if (pos < MASK_W) m[pos] = 1'b1;
      end
      return m;
   endfunction

   task automatic restore_defaults();
      cfg_dir      = 1'b0;
      cfg_tail_len = TAIL_LENGTH_RST;
      cfg_debounce = DEBOUNCE_RST;
      cfg_step     = PERIOD_STEP_RST;
      cfg_min      = PERIOD_MIN_RST;
      cfg_max      = PERIOD_MAX_RST;
      last_a       = 1'b1;
      run_per      = RUNNER_PERIOD_RST;
      trail_per    = TAIL_PERIOD_RST;
      run_age      = '0;
      trail_age    = '0;
      run_pos      = '0;
      trail_pos    = '0;
      btn_down     = 1'b0;
      btn_quiet    = QUIET_MAX;
      trail_on     = 1'b0;
      lit          = MASK_W'(1);
   endtask

   task automatic apply_setting(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (csr_index_type'(idx))
         CSR_DIRECTION:   cfg_dir      = data[0];
         CSR_TAIL_LENGTH: cfg_tail_len = data[TAIL_W-1:0];
         CSR_DEBOUNCE_MS: cfg_debounce = data[QUIET_W-1:0];
         CSR_PERIOD_STEP: cfg_step     = data[STEP_W-1:0];
         CSR_PERIOD_MIN:  cfg_min      = data[PERIOD_W-1:0];
         CSR_PERIOD_MAX:  cfg_max      = data[PERIOD_W-1:0];
         default: ;
      endcase
   endtask

   // One millisecond tick: encoder, then button, then animation.
   task automatic advance_ring_tick(logic a, logic b, logic btn_n);
      ring_status_type st;
      int              delta;
      int              q;
      logic            pressed;
      st = '0;
      if (a != last_a) begin
         delta  = (a == b) ? int'(cfg_step) : -int'(cfg_step);
         last_a = a;
         run_per   = clamp_to_limits(int'(run_per) - delta);
         trail_per = clamp_to_limits(int'(trail_per) - delta);
         st.speed_changed = 1'b1;
      end
      q = (btn_quiet < QUIET_MAX) ? int'(btn_quiet) + 1 : int'(QUIET_MAX);
      pressed = !btn_n;
      if (pressed != btn_down && q > int'(cfg_debounce)) begin
         btn_down = pressed;
         q = 0;
         if (pressed) trail_on = !trail_on;
      end
      btn_quiet = q[QUIET_W-1:0];
      // both ages run all the time; only the active one is tested
      if (run_age < ELAPSED_MAX) run_age++;
      if (trail_age < ELAPSED_MAX) trail_age++;
      if (!trail_on) begin
         if (run_age >= run_per) begin
            run_age = '0;
            run_pos = ring_next(run_pos);
            lit = MASK_W'(1) << run_pos;
            st.mask_written = 1'b1;
         end
      end else if (trail_age >= trail_per) begin
         trail_age = '0;
         trail_pos = ring_next(trail_pos);
         lit = trail_mask(trail_pos);
         st.mask_written = 1'b1;
      end
      st.led_mask      = lit;
      st.tail_mode     = trail_on;
      st.runner_period = run_per;
      st.tail_period   = trail_per;
      status_due_q.push_back(st);
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         fail_total++;
      end
   endtask

   always @(posedge clock) begin : watch
      ring_status_type want;
      if (reset) begin
         restore_defaults();
         status_due_q.delete();
      end else begin
         if (csr_wr_en) apply_setting(csr_index, csr_wdata);
         if (req_mon.valid && req_mon.ready)
            advance_ring_tick(req_mon.enc_a, req_mon.enc_b, req_mon.button_n);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (status_due_q.size() == 0) begin
               $display("%0t: status word with none expected, mask %h", $time,
                        rsp_mon.led_mask);
               fail_total++;
            end else begin
               want = status_due_q.pop_front();
               check_field("led_mask", 32'(want.led_mask), 32'(rsp_mon.led_mask));
               check_field("mask_written", 32'(want.mask_written),
                           32'(rsp_mon.mask_written));
               check_field("tail_mode", 32'(want.tail_mode), 32'(rsp_mon.tail_mode));
               check_field("runner_period", 32'(want.runner_period),
                           32'(rsp_mon.runner_period));
               check_field("tail_period", 32'(want.tail_period),
                           32'(rsp_mon.tail_period));
               check_field("speed_changed", 32'(want.speed_changed),
                           32'(rsp_mon.speed_changed));
            end
         end
      end
      due_count = status_due_q.size();
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives tick words and register writes into the LED ring animator and lets
// the checker compare every status word; prints the verdict at the end.
// ----------------------------------------------------------------------------
module testbench;
   import elra_pkg::*;

   // indexes past the last register; writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;
   localparam int HOLD_CYCLES = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fails;
   int                    outstanding;

   // stimulus state shared by the sender and receiver processes
   bit   idle_on  = 1'b1;
   bit   hold_rsp = 1'b0;
   bit   spin_cw  = 1'b1;
   int   deb_now  = 10;
   int   btn_run  = 0;
   logic cur_a    = 1'b1;
   logic cur_b    = 1'b1;
   logic cur_btn  = 1'b1;

   // {enc_a, enc_b, button_n}; encoder steps both ways, a press that
   // toggles the mode, a bounce that is rejected and a late release
   logic [2:0] warmup [21] = '{
      3'b111, 3'b001, 3'b101, 3'b011, 3'b110, 3'b111, 3'b110, 3'b110,
      3'b110, 3'b110, 3'b110, 3'b110, 3'b110, 3'b110, 3'b110, 3'b110,
      3'b110, 3'b111, 3'b011, 3'b001, 3'b101
   };

   elra_req_if req_chan ();
   elra_rsp_if rsp_chan ();

   encoder_led_ring_animator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   elra_tick_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fails       (fails),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random hold-off before each word, or a long hold on request.
   initial begin : receiver
      int n;
      rsp_chan.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            n = HOLD_CYCLES;
         end else begin
            n = idle_on ? $urandom_range(0, 3) : 0;
         end
         if (n > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         @(negedge clock);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_tick(logic a, logic b, logic btn_n);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.enc_a    <= a;
      req_chan.enc_b    <= b;
      req_chan.button_n <= btn_n;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      @(negedge clock);
   endtask

   // Stop sending and wait for every outstanding status word.
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic setup_phase(logic dir, logic [TAIL_W-1:0] tail_len,
                              logic [QUIET_W-1:0] debounce, logic [STEP_W-1:0] step,
                              logic [PERIOD_W-1:0] lo, logic [PERIOD_W-1:0] hi,
                              bit poke_unused);
      write_reg(CSR_DIRECTION, CSR_DATA_W'(dir));
      write_reg(CSR_TAIL_LENGTH, CSR_DATA_W'(tail_len));
      write_reg(CSR_DEBOUNCE_MS, CSR_DATA_W'(debounce));
      write_reg(CSR_PERIOD_STEP, CSR_DATA_W'(step));
      write_reg(CSR_PERIOD_MIN, CSR_DATA_W'(lo));
      write_reg(CSR_PERIOD_MAX, CSR_DATA_W'(hi));
      if (poke_unused) begin
         write_reg(CSR_UNUSED_LO, '1);
         write_reg(CSR_UNUSED_HI, '0);
      end
      csr_wr_en <= 1'b0;
      deb_now = int'(debounce);
   endtask

   // Mostly clean quadrature rotation with occasional reversal and line
   // noise; the button is held for runs that mostly outlast the debounce,
   // with short bounces mixed in.
   task automatic random_tick();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         if (spin_cw ^ (cur_a == cur_b)) cur_a = !cur_a;
         else cur_b = !cur_b;
      end else if (r < 36) begin
         cur_a = 1'($urandom_range(0, 1));
         cur_b = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 99) < 4) spin_cw = !spin_cw;
      if (btn_run == 0) begin
         cur_btn = !cur_btn;
         if ($urandom_range(0, 4) == 0) btn_run = $urandom_range(1, 3);
         else btn_run = deb_now + 1 + $urandom_range(0, 12);
         if (btn_run > 60) btn_run = $urandom_range(20, 60);
      end else begin
         btn_run--;
      end
      send_tick(cur_a, cur_b, cur_btn);
   endtask

   task automatic run_random(int count, bit idle, bit hold, bit pause);
      idle_on = idle;
      for (int i = 0; i < count; i++) begin
         if (hold && i == count / 3) hold_rsp = 1'b1;
         if (pause && i == count / 2) drain();
         random_tick();
      end
      drain();
   endtask

   initial begin : stimulus
      req_chan.valid    = 1'b0;
      req_chan.enc_a    = 1'b1;
      req_chan.enc_b    = 1'b1;
      req_chan.button_n = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words at the reset settings
      foreach (warmup[i]) send_tick(warmup[i][2], warmup[i][1], warmup[i][0]);
      cur_a   = warmup[20][2];
      cur_b   = warmup[20][1];
      cur_btn = warmup[20][0];
      drain();

      // fast ring, no debounce, long receiver hold
      setup_phase(1'b1, 5'd16, 8'd0, 6'd1, 10'd1, 10'd8, 1'b0);
      run_random(150, 1'b1, 1'b1, 1'b0);
      // empty tail, zero period possible, widest clamp, no idling
      setup_phase(1'b0, 5'd0, 8'd3, 6'd63, 10'd0, 10'd1023, 1'b0);
      run_random(120, 1'b0, 1'b0, 1'b0);
      // tail wraps the ring, button never accepted, unused indexes written
      setup_phase(1'b1, 5'd31, 8'd255, 6'd2, 10'd2, 10'd6, 1'b1);
      run_random(120, 1'b1, 1'b0, 1'b0);
      // minimum above maximum, zero step, sender pauses mid-phase
      setup_phase(1'b0, 5'd1, 8'd1, 6'd0, 10'd1023, 10'd5, 1'b0);
      run_random(120, 1'b1, 1'b0, 1'b1);
      // tail just past the ring, back-to-back words with a receiver hold
      setup_phase(1'b0, 5'd17, 8'd5, 6'd1, 10'd0, 10'd4, 1'b0);
      run_random(140, 1'b0, 1'b1, 1'b0);
      // both periods forced to zero: a step every tick
      setup_phase(1'b1, 5'd15, 8'd2, 6'd7, 10'd0, 10'd0, 1'b0);
      run_random(100, 1'b1, 1'b0, 1'b0);

      repeat (3) begin
         setup_phase(1'($urandom_range(0, 1)), TAIL_W'($urandom_range(0, 31)),
                     QUIET_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 12)),
                     STEP_W'($urandom_range(0, 63)), PERIOD_W'($urandom_range(0, 15)),
                     PERIOD_W'($urandom_range(0, 40)), 1'b0);
         run_random(130, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
      end

      repeat (4) @(negedge clock);
      if (fails == 0) begin
         $display("encoder_led_ring_animator_unit: match");
      end else begin
         $display("encoder_led_ring_animator_unit: mismatch");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("encoder_led_ring_animator_unit: mismatch");
      $finish;
   end

endmodule
